### src/assert_macros.svh
// Shared assertion macros for the statement condenser checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/csc_pkg.sv
package csc_pkg;

    // Field widths
    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 13;
    localparam int STMT_LEN_W  = 12;
    localparam int LINE_W      = 32;
    localparam int OUT_FIELD_W = BYTE_W + STMT_LEN_W + LINE_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Largest buffer length the register can carry
    localparam int CFG_MAX     = (1 << CFG_W) - 1;
    localparam int CFG_RESET   = 1024;

    // Characters with a meaning of their own
    localparam logic [BYTE_W-1:0] CHAR_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CHAR_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'h09;

    typedef enum logic [3:0] {
        MODE_NORMAL  = 4'b0001,
        MODE_COMMENT = 4'b0010,
        MODE_BLANK   = 4'b0100,
        MODE_ESCAPE  = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] next_byte;
        logic              end_of_input;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]     out_byte;
        logic                  is_last;
        logic [STMT_LEN_W-1:0] statement_length;
        logic [LINE_W-1:0]     line_count;
        logic                  input_ended;
    } res_t;

endpackage

### src/csc_in_stage.sv
module csc_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_valid,
    output logic           s_ready,
    input  csc_pkg::item_t s_item,
    input  logic           take,
    output logic           item_valid,
    output csc_pkg::item_t item
);
    import csc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept a new beat when nothing is held or the held one moves on this cycle
    assign s_ready    = !valid_reg || take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until it is consumed
    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### src/csc_scan.sv
module csc_scan #(
    parameter int MAX_BUFFER = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [csc_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          step,
    input  csc_pkg::item_t                item,
    output logic                          emit,
    output csc_pkg::res_t                 res
);
    import csc_pkg::*;

    localparam int CAP_INT  = (MAX_BUFFER > CFG_MAX) ? CFG_MAX : MAX_BUFFER;
    localparam int KEEP_W   = $clog2(CAP_INT);
    localparam int RST_SIZE = (CFG_RESET > CAP_INT) ? CAP_INT : CFG_RESET;
    localparam logic [CFG_W-1:0]  CAP       = CFG_W'(CAP_INT);
    localparam logic [KEEP_W-1:0] RST_LIMIT = KEEP_W'(RST_SIZE - 1);

    mode_t              mode_reg;
    mode_t              mode_next;
    logic [KEEP_W-1:0]  kept_reg;
    logic [KEEP_W-1:0]  kept_next;
    logic [LINE_W-1:0]  lines_reg;
    logic [LINE_W-1:0]  lines_next;
    logic [KEEP_W-1:0]  limit_reg;
    logic [KEEP_W-1:0]  limit_next;
    logic [CFG_W-1:0]   cfg_size;

    logic [BYTE_W-1:0]  c;
    logic               blank;
    logic               room;
    logic               run_normal;

    // Turn the buffer length into the highest kept count once, at write time
    always_comb
    begin
        cfg_size   = (cfg_wr_data > CAP) ? CAP : cfg_wr_data;
        limit_next = limit_reg;
        if (cfg_wr_en)
        begin
            limit_next = (cfg_size == '0) ? '0 : KEEP_W'(cfg_size - 1'b1);
        end
    end

    assign c     = item.next_byte;
    assign blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
    assign room  = kept_reg < limit_reg;

    // Mode update and result forming for one byte
    always_comb
    begin
        mode_next  = mode_reg;
        kept_next  = kept_reg;
        lines_next = lines_reg;
        emit       = 1'b0;
        res        = '0;
        run_normal = 1'b0;

        if (item.end_of_input)
        begin
            emit                 = 1'b1;
            res.is_last          = 1'b1;
            res.statement_length = STMT_LEN_W'(kept_reg);
            res.line_count       = lines_reg;
            res.input_ended      = 1'b1;
            kept_next            = '0;
            mode_next            = MODE_NORMAL;
        end
        else
        begin
            unique case (mode_reg)
                MODE_COMMENT:
                begin
                    run_normal = (c == CHAR_LF);
                end
                MODE_BLANK:
                begin
                    run_normal = !blank;
                end
                MODE_ESCAPE:
                begin
                    mode_next = MODE_NORMAL;
                    if (c == CHAR_LF)
                    begin
                        lines_next = lines_reg + 1'b1;
                    end
                    else
                    begin
                        run_normal = 1'b1;
                    end
                end
                default:
                begin
                    run_normal = 1'b1;
                end
            endcase

            // Plain handling of a byte outside any pending mode
            if (run_normal)
            begin
                mode_next = MODE_NORMAL;
                if (c == CHAR_HASH)
                begin
                    mode_next = MODE_COMMENT;
                end
                else if (blank)
                begin
                    if (kept_reg != '0)
                    begin
                        mode_next = MODE_BLANK;
                        if (room)
                        begin
                            kept_next    = kept_reg + 1'b1;
                            emit         = 1'b1;
                            res.out_byte = CHAR_SPACE;
                        end
                    end
                end
                else if (c == CHAR_BSLASH)
                begin
                    mode_next = MODE_ESCAPE;
                end
                else if (c == CHAR_LF)
                begin
                    lines_next = lines_reg + 1'b1;
                    if (kept_reg != '0)
                    begin
                        emit                 = 1'b1;
                        res.is_last          = 1'b1;
                        res.statement_length = STMT_LEN_W'(kept_reg);
                        res.line_count       = lines_reg + 1'b1;
                        kept_next            = '0;
                    end
                end
                else if (room)
                begin
                    kept_next    = kept_reg + 1'b1;
                    emit         = 1'b1;
                    res.out_byte = c;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            kept_reg  <= '0;
            lines_reg <= '0;
            limit_reg <= RST_LIMIT;
        end
        else
        begin
            limit_reg <= limit_next;
            if (step)
            begin
                mode_reg  <= mode_next;
                kept_reg  <= kept_next;
                lines_reg <= lines_next;
            end
        end
    end

endmodule

### src/csc_out_buf.sv
module csc_out_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  csc_pkg::res_t push_res,
    output logic          space,
    output logic          m_valid,
    input  logic          m_ready,
    output csc_pkg::res_t m_res
);
    import csc_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t out_res_reg;
    res_t skid_res_reg;
    logic pop;
    logic load_out;
    logic load_skid;
    logic out_from_skid;

    assign pop   = out_valid_reg && m_ready;
    assign space = !skid_valid_reg;

    // Steer a pushed result to the output or the skid entry; on a pop, refill the output from the skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_from_skid   = 1'b1;
                load_out        = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                load_out       = push;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold result payloads
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_res_reg <= out_from_skid ? skid_res_reg : push_res;
        end
        if (load_skid)
        begin
            skid_res_reg <= push_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_res_reg;

endmodule

### src/config_statement_condenser.sv
// Configuration statement condenser.
// Input stream (s_axis): one raw file byte per beat in tdata; tlast marks end
// of file, in which case tdata is ignored. Output stream (m_axis): one beat per
// kept statement character, or a tlast beat that closes a statement and
// carries its length and the running newline count; tuser flags a statement
// closed by end of file. Blank runs collapse to one space, comments and
// backslash escapes are removed, backslash-newline joins lines.
// cfg_wr_en / cfg_wr_data write buffer_length (at most buffer_length-1
// characters of a statement are kept); write it only while the block is idle.
// A result is shown on m_axis once its byte has passed the input register,
// then the result register. Throughput: one byte per cycle while the result
// buffer has room, set by the combinational mode update between the two registers.
// Reset clears mode, kept count and newline count, and sets buffer_length to
// 1024. When m_axis_tready is low, a two-entry result buffer absorbs results;
// once both entries are full, the byte held in the input register waits and
// s_axis_tready drops; it rises again the cycle after a beat is taken.
module config_statement_condenser #(
    parameter int MAX_BUFFER = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [csc_pkg::CFG_W-1:0]          cfg_wr_data,   // buffer_length
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [csc_pkg::BYTE_W-1:0]         s_axis_tdata,  // [7:0] next_byte
    input  logic                               s_axis_tlast,  // end_of_input
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] out_byte, [19:8] statement_length, [51:20] line_count, rest zero
    output logic [csc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,  // is_last
    output logic                               m_axis_tuser   // input_ended
);
    import csc_pkg::*;

    item_t s_item;
    item_t item;
    logic  item_valid;
    logic  take;
    logic  space;
    logic  emit;
    res_t  res;
    res_t  m_res;

    assign s_item.next_byte    = s_axis_tdata;
    assign s_item.end_of_input = s_axis_tlast;

    // A held byte advances whenever the result buffer has room
    assign take = item_valid && space;

    csc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    csc_scan #(
        .MAX_BUFFER (MAX_BUFFER)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (take),
        .item        (item),
        .emit        (emit),
        .res         (res)
    );

    csc_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (take && emit),
        .push_res (res),
        .space    (space),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_res    (m_res)
    );

    // Pack the result fields onto the master beat
    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}},
                           m_res.line_count, m_res.statement_length, m_res.out_byte};
    assign m_axis_tlast = m_res.is_last;
    assign m_axis_tuser = m_res.input_ended;

endmodule

### src/csc_checker.sv
`include "assert_macros.svh"

module csc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [csc_pkg::BYTE_W-1:0]      s_axis_tdata,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [csc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic                            m_axis_tuser
);
    import csc_pkg::*;

    // A stalled slave beat is held by the sender
    `CSC_ASSERT_NEXT(a_in_hold, clk, rst_n, s_axis_tvalid && !s_axis_tready,
        s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast),
        "slave beat changed while stalled")

    // A stalled master beat keeps its payload
    `CSC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
        && $stable(m_axis_tuser), "master beat changed while stalled")

    // Character beats carry no length, line count or end-of-file flag
    `CSC_ASSERT_IMPLY(a_char_clean, clk, rst_n, m_axis_tvalid && !m_axis_tlast,
        m_axis_tdata[OUT_FIELD_W-1:BYTE_W] == '0 && !m_axis_tuser,
        "character beat carries statement fields")

    // Closing beats carry a zero character
    `CSC_ASSERT_IMPLY(a_last_byte, clk, rst_n, m_axis_tvalid && m_axis_tlast,
        m_axis_tdata[BYTE_W-1:0] == '0, "closing beat has a character")

    // End of file only ever closes a statement
    `CSC_ASSERT_IMPLY(a_end_is_last, clk, rst_n, m_axis_tvalid && m_axis_tuser,
        m_axis_tlast, "end-of-file flag on a character beat")

endmodule

bind config_statement_condenser csc_checker u_csc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import csc_pkg::*;

    localparam int BUF_CAP       = 4096;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 120;
    localparam int QUIET_LIMIT   = 2000;
    localparam int N_PHASES      = 10;
    localparam int PHASE_BYTES   = 60;
    localparam int N_SCRIPT      = 25;

    // one row of the directed script; want is only meaningful when typed is set
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              eoi;
        bit                typed;
        res_t              want;
    } script_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_W-1:0]       cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata;   // [7:0] next_byte
    logic                   s_axis_tlast;   // end_of_input
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [7:0] out_byte, [19:8] statement_length, [51:20] line_count, rest zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;   // is_last
    logic                   m_axis_tuser;   // input_ended

    // condenser state as predicted
    logic [CFG_W-1:0]       buf_len;
    mode_t                  scan;
    logic [CFG_W-1:0]       kept;
    logic [LINE_W-1:0]      lines_seen;

    res_t                   condensed_q[$];
    int                     error_count = 0;
    int                     bytes_sent = 0;
    int                     beats_checked = 0;
    int                     stmts_closed = 0;
    int                     gap_max = 8;
    bit                     hold_req = 1'b0;

    config_statement_condenser #(
        .MAX_BUFFER(BUF_CAP)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always #10 clk = ~clk;

    task automatic flag_error(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    // characters a statement may hold under the current buffer length
    function automatic logic [CFG_W-1:0] keep_limit();
        logic [CFG_W-1:0] size;
        size = (buf_len > BUF_CAP) ? CFG_W'(BUF_CAP) : buf_len;
        return (size == '0) ? '0 : size - 1'b1;
    endfunction

    // handle a byte outside any comment, blank run or escape
    function automatic bit take_plain(input logic [BYTE_W-1:0] c, output res_t r);
        r = '0;
        if (c == CHAR_HASH) begin
            scan = MODE_COMMENT;
            return 1'b0;
        end
        if (c == CHAR_SPACE || c == CHAR_TAB) begin
            if (kept == '0)
                return 1'b0;
            scan = MODE_BLANK;
            if (kept < keep_limit()) begin
                kept++;
                r.out_byte = CHAR_SPACE;
                return 1'b1;
            end
            return 1'b0;
        end
        if (c == CHAR_BSLASH) begin
            scan = MODE_ESCAPE;
            return 1'b0;
        end
        if (c == CHAR_LF) begin
            lines_seen++;
            if (kept == '0)
                return 1'b0;
            r.is_last          = 1'b1;
            r.statement_length = kept[STMT_LEN_W-1:0];
            r.line_count       = lines_seen;
            kept = '0;
            return 1'b1;
        end
        if (kept < keep_limit()) begin
            kept++;
            r.out_byte = c;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the predicted condenser by one byte; returns 1 when a beat is due
    function automatic bit condense_step(input logic [BYTE_W-1:0] c, input logic eoi,
                                         output res_t r);
        r = '0;
        if (eoi) begin
            r.is_last          = 1'b1;
            r.statement_length = kept[STMT_LEN_W-1:0];
            r.line_count       = lines_seen;
            r.input_ended      = 1'b1;
            kept = '0;
            scan = MODE_NORMAL;
            return 1'b1;
        end
        case (scan)
            MODE_COMMENT:
            begin
                if (c != CHAR_LF)
                    return 1'b0;
                scan = MODE_NORMAL;
                return take_plain(c, r);
            end
            MODE_BLANK:
            begin
                if (c == CHAR_SPACE || c == CHAR_TAB)
                    return 1'b0;
                scan = MODE_NORMAL;
                return take_plain(c, r);
            end
            MODE_ESCAPE:
            begin
                scan = MODE_NORMAL;
                if (c == CHAR_LF) begin
                    lines_seen++;
                    return 1'b0;
                end
                return take_plain(c, r);
            end
            default:
            begin
                scan = MODE_NORMAL;
                return take_plain(c, r);
            end
        endcase
    endfunction

    // offer one byte after a random gap, hold until accepted, then predict
    task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic eoi, input bit typed,
                              input res_t want);
        int   gap;
        bit   due;
        res_t r;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eoi;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
        due = condense_step(b, eoi, r);
        if (typed) begin
            due = 1'b1;
            r   = want;
        end
        if (due)
            condensed_q.push_back(r);
    endtask

    // drop valid and wait until the block has nothing left in flight
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (condensed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // compare one output beat against the oldest expectation
    task automatic check_beat(input logic [OUT_TDATA_W-1:0] data, input logic last,
                              input logic user);
        res_t want;
        if (condensed_q.size() == 0) begin
            flag_error($sformatf("beat %0d arrived with nothing expected", beats_checked));
            beats_checked++;
            return;
        end
        want = condensed_q.pop_front();
        if (data[BYTE_W-1:0] !== want.out_byte)
            flag_error($sformatf("beat %0d out_byte %h, want %h",
                                 beats_checked, data[BYTE_W-1:0], want.out_byte));
        if (last !== want.is_last)
            flag_error($sformatf("beat %0d is_last %b, want %b",
                                 beats_checked, last, want.is_last));
        if (data[BYTE_W +: STMT_LEN_W] !== want.statement_length)
            flag_error($sformatf("beat %0d statement_length %0d, want %0d", beats_checked,
                                 data[BYTE_W +: STMT_LEN_W], want.statement_length));
        if (data[BYTE_W+STMT_LEN_W +: LINE_W] !== want.line_count)
            flag_error($sformatf("beat %0d line_count %0d, want %0d", beats_checked,
                                 data[BYTE_W+STMT_LEN_W +: LINE_W], want.line_count));
        if (user !== want.input_ended)
            flag_error($sformatf("beat %0d input_ended %b, want %b",
                                 beats_checked, user, want.input_ended));
        if ((data >> OUT_FIELD_W) !== '0)
            flag_error($sformatf("beat %0d padding bits not zero: %h", beats_checked, data));
        if (want.is_last)
            stmts_closed++;
        beats_checked++;
    endtask

    // receiver: random back-pressure per beat, plus one long hold on request
    initial
    begin
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
                idle_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            end else if (idle_left > 0) begin
                idle_left--;
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            m_axis_tready <= (idle_left == 0 && hold_left == 0);
        end
    end

    // watchdog: end the run if nothing moves for too long
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // stimulus: directed script at the reset buffer length, then random phases
    initial
    begin
        script_row_t      script [N_SCRIPT];
        logic [CFG_W-1:0] cfg_plan [N_PHASES];
        logic [BYTE_W-1:0] b;
        logic             eoi;
        int               pick;

        script = '{
            // end of input right after reset: empty statement, no lines yet
            '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 12'd0, 32'd0, 1'b1}},
            '{"a", 1'b0, 1'b1, '{"a", 1'b0, 12'd0, 32'd0, 1'b0}},
            // blank run collapses to one space
            '{CHAR_SPACE, 1'b0, 1'b0, '0},
            '{CHAR_TAB, 1'b0, 1'b0, '0},
            '{CHAR_SPACE, 1'b0, 1'b0, '0},
            '{"b", 1'b0, 1'b0, '0},
            // trailing blank still kept before the newline
            '{CHAR_TAB, 1'b0, 1'b0, '0},
            '{CHAR_LF, 1'b0, 1'b1, '{8'h00, 1'b1, 12'd4, 32'd1, 1'b0}},
            // leading blank, then an empty line
            '{CHAR_SPACE, 1'b0, 1'b0, '0},
            '{CHAR_LF, 1'b0, 1'b0, '0},
            // comment swallows everything up to the newline
            '{CHAR_HASH, 1'b0, 1'b0, '0},
            '{"x", 1'b0, 1'b0, '0},
            '{CHAR_BSLASH, 1'b0, 1'b0, '0},
            '{CHAR_LF, 1'b0, 1'b0, '0},
            // backslash-newline joins lines
            '{"k", 1'b0, 1'b0, '0},
            '{CHAR_BSLASH, 1'b0, 1'b0, '0},
            '{CHAR_LF, 1'b0, 1'b0, '0},
            // escaped hash still opens a comment
            '{CHAR_BSLASH, 1'b0, 1'b0, '0},
            '{CHAR_HASH, 1'b0, 1'b0, '0},
            '{"z", 1'b0, 1'b0, '0},
            '{CHAR_LF, 1'b0, 1'b0, '0},
            // byte extremes
            '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b0, 12'd0, 32'd0, 1'b0}},
            '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 12'd0, 32'd0, 1'b0}},
            // pending escape dropped by end of input; data ignored there
            '{CHAR_BSLASH, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b1, 12'd2, 32'd5, 1'b1}}
        };
        cfg_plan = '{13'd8191, 13'd0, 13'd1, 13'd2, 13'd3, 13'd4096, 13'd4097,
                     13'd8, 13'd100, 13'd5};
        cfg_plan[7] = CFG_W'($urandom_range(4, 16));
        cfg_plan[8] = CFG_W'($urandom_range(2, CFG_MAX));

        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        buf_len    = CFG_W'(CFG_RESET);
        scan       = MODE_NORMAL;
        kept       = '0;
        lines_seen = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            offer_byte(script[i].data, script[i].eoi, script[i].typed, script[i].want);
        settle();

        for (int p = 0; p < N_PHASES; p++) begin
            // reprogram the buffer length while idle
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= cfg_plan[p];
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            buf_len = cfg_plan[p];

            gap_max = (p % 3 == 1) ? 0 : 8;
            if (p == 3)
                hold_req = 1'b1;

            for (int n = 0; n < PHASE_BYTES; n++) begin
                pick = $urandom_range(0, 99);
                b    = BYTE_W'($urandom_range(0, 255));
                eoi  = 1'b0;
                if (pick < 40)
                    b = BYTE_W'($urandom_range(8'h61, 8'h7A));
                else if (pick < 52)
                    b = CHAR_SPACE;
                else if (pick < 58)
                    b = CHAR_TAB;
                else if (pick < 68)
                    b = CHAR_LF;
                else if (pick < 73)
                    b = CHAR_HASH;
                else if (pick < 79)
                    b = CHAR_BSLASH;
                else if (pick >= 97)
                    eoi = 1'b1;
                offer_byte(b, eoi, 1'b0, '0);
            end
            settle();
        end

        if (condensed_q.size() != 0)
            flag_error($sformatf("%0d expected beats never arrived", condensed_q.size()));

        $display("covered %0d input bytes over %0d buffer lengths, incl. 0, 1, 2, 4096, max",
                 bytes_sent, N_PHASES + 1);
        $display("checked %0d output beats, %0d statements closed, %0d mismatches",
                 beats_checked, stmts_closed, error_count);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
